FILE: hdl/gbpf_pkg.sv
// ----------------------------------------------------------------------------
// gbpf_pkg
// Shared types and constants for the glyph blitter: function codes, status
// codes, configuration indexes and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package gbpf_pkg;

    // Printable character range held in the glyph store
    localparam logic [7:0] FIRST_CODE  = 8'd32;
    localparam logic [7:0] LAST_CODE   = 8'd126;
    localparam int         GLYPH_COUNT = 95;

    // Field and register widths
    localparam int FONT_W_W   = 5;
    localparam int FONT_H_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_CURSOR = 2'd1,
        FUNC_DRAW   = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CODE = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_WIDTH  = 1'd0,
        CFG_FONT_HEIGHT = 1'd1
    } cfg_idx_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;      // zero one frame byte of the reset sweep
        logic take;       // latch the accepted item
        logic check;      // evaluate the item, do single-step work
        logic fetch;      // read one glyph row
        logic col_read;   // read one frame byte of the glyph cell
        logic col_write;  // merge and write that frame byte
        logic finish;     // load the result register, update the cursor
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic draw_go;
        logic fetch_last;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/gbpf_if.sv
// ----------------------------------------------------------------------------
// gbpf_in_if / gbpf_out_if
// Valid/ready channels for the glyph blitter: request items in, result
// items out.
// ----------------------------------------------------------------------------
interface gbpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [4:0]  glyph_row;
    logic [15:0] row_bits;
    logic        ink_color;
    logic [7:0]  set_x;
    logic [4:0]  set_y;
    logic [8:0]  read_address;

    modport source (
        output valid, func, char_code, glyph_row, row_bits, ink_color,
               set_x, set_y, read_address,
        input  ready
    );
    modport sink (
        input  valid, func, char_code, glyph_row, row_bits, ink_color,
               set_x, set_y, read_address,
        output ready
    );
endinterface

interface gbpf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] echo_char;
    logic [7:0] read_byte;

    modport source (
        output valid, status, echo_char, read_byte,
        input  ready
    );
    modport sink (
        input  valid, status, echo_char, read_byte,
        output ready
    );
endinterface

FILE: hdl/gbpf_ctrl.sv
// ----------------------------------------------------------------------------
// gbpf_ctrl
// Sequencer for the glyph blitter: reset sweep of the frame buffer, item
// intake, glyph row fetch, read-modify-write walk over the glyph cell and
// result handoff.
// ----------------------------------------------------------------------------
module gbpf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output gbpf_pkg::dp_cmd_t  cmd,
    input  gbpf_pkg::dp_stat_t stat
);
    import gbpf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands from the current state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.draw_go ? ST_FETCH : ST_DONE;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.fetch_last)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.col_read = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.col_write = 1'b1;
                state_next    = stat.walk_last ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state; reset starts the frame buffer sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/gbpf_datapath.sv
// ----------------------------------------------------------------------------
// gbpf_datapath
// Storage and arithmetic of the glyph blitter: font registers, cursor, glyph
// store, frame buffer, glyph row bank, cell walk counters, pixel merge and
// the result register.
// ----------------------------------------------------------------------------
module gbpf_datapath #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_ROWS    = 32,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gbpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbpf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gbpf_pkg::dp_cmd_t                   cmd,
    output gbpf_pkg::dp_stat_t                  stat,
    input  logic [1:0]                          func,
    input  logic [7:0]                          char_code,
    input  logic [4:0]                          glyph_row,
    input  logic [15:0]                         row_bits,
    input  logic                                ink_color,
    input  logic [7:0]                          set_x,
    input  logic [4:0]                          set_y,
    input  logic [8:0]                          read_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [7:0]                          echo_char,
    output logic [7:0]                          read_byte
);
    import gbpf_pkg::*;

    localparam int FRAME_BYTES = (SCREEN_COLUMNS * SCREEN_ROWS) / 8;
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int PAGES       = SCREEN_ROWS / 8;
    localparam int PG_W        = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int GLYPH_WORDS = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int GA_W        = $clog2(GLYPH_WORDS);
    localparam int RW          = $clog2(MAX_GLYPH_ROWS);
    localparam int EXT_W       = SCREEN_ROWS + 8;
    localparam int SH_W        = $clog2(SCREEN_ROWS + 1);

    // Latched item
    func_t       func_reg;
    logic [7:0]  code_reg;
    logic [4:0]  grow_reg;
    logic [15:0] rbits_reg;
    logic        ink_reg;
    logic [7:0]  setx_reg;
    logic [4:0]  sety_reg;
    logic [8:0]  raddr_reg;

    // Configuration and cursor
    logic [FONT_W_W-1:0] font_width_reg;
    logic [FONT_H_W-1:0] font_height_reg;
    logic [7:0]          cx_reg;
    logic [4:0]          cy_reg;

    // Walk state
    logic [1:0]      status_reg;
    logic [RW-1:0]   row_cnt_reg;
    logic [RW-1:0]   fetch_top_reg;
    logic            cap_valid_reg;
    logic [RW-1:0]   cap_row_reg;
    logic [15:0]     g_rdata_reg;
    logic [15:0]     glyph_rows_reg [MAX_GLYPH_ROWS];
    logic [4:0]      col_cnt_reg;
    logic [PG_W-1:0] page_cnt_reg;
    logic [PG_W-1:0] first_page_reg;
    logic [PG_W-1:0] last_page_reg;
    logic [FA_W-1:0] clr_cnt_reg;
    logic [7:0]      f_rdata_reg;

    // Result register
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_echo_reg;
    logic [7:0] out_byte_reg;

    // Memories
    logic [15:0] glyph_mem [GLYPH_WORDS];
    logic [7:0]  frame_mem [FRAME_BYTES];

    // Combinational
    logic                   code_ok;
    logic                   fit_ok;
    logic                   raddr_ok;
    logic [1:0]             status_c;
    logic [GA_W-1:0]        glyph_base;
    logic                   gw_en;
    logic [GA_W-1:0]        gw_addr;
    logic [GA_W-1:0]        gr_addr;
    logic [7:0]             walk_x;
    logic [FA_W-1:0]        walk_addr;
    logic [FA_W-1:0]        raddr_fa;
    logic                   f_we;
    logic [FA_W-1:0]        f_waddr;
    logic [7:0]             f_wdata;
    logic                   f_re;
    logic [FA_W-1:0]        f_raddr;
    logic [SCREEN_ROWS-1:0] colvec;
    logic [SCREEN_ROWS-1:0] mvec;
    logic [SH_W-1:0]        sh;
    logic [EXT_W-1:0]       gext;
    logic [EXT_W-1:0]       mext;
    logic [7:0]             set8;
    logic [7:0]             mask8;
    logic [7:0]             val8;
    logic                   draw_ok;

    // Classify the latched item
    always_comb
    begin
        code_ok = (code_reg >= FIRST_CODE) && (code_reg <= LAST_CODE);
        fit_ok  = (({1'b0, cx_reg} + 9'(font_width_reg)) <= 9'(SCREEN_COLUMNS)) &&
                  ((7'(cy_reg) + 7'(font_height_reg)) <= 7'(SCREEN_ROWS));
        raddr_ok = 32'(raddr_reg) < FRAME_BYTES;
        status_c = STATUS_OK;
        unique case (func_reg)
            FUNC_LOAD:
            begin
                if (!code_ok)
                    status_c = STATUS_BAD_CODE;
                else if (6'(grow_reg) >= 6'(MAX_GLYPH_ROWS))
                    status_c = STATUS_NO_FIT;
            end
            FUNC_DRAW:
            begin
                if (!code_ok)
                    status_c = STATUS_BAD_CODE;
                else if (!fit_ok)
                    status_c = STATUS_NO_FIT;
            end
            FUNC_CURSOR, FUNC_READ:
            begin
                status_c = STATUS_OK;
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    // Glyph store addressing
    assign glyph_base = GA_W'((32'(code_reg) - 32'(FIRST_CODE)) * MAX_GLYPH_ROWS);
    assign gw_en      = cmd.check && (func_reg == FUNC_LOAD) && (status_c == STATUS_OK);
    assign gw_addr    = glyph_base + GA_W'(grow_reg);
    assign gr_addr    = glyph_base + GA_W'(row_cnt_reg);

    // Frame buffer addressing for the cell walk and for byte reads
    assign walk_x    = cx_reg + {3'b000, col_cnt_reg};
    assign walk_addr = FA_W'(32'(page_cnt_reg) * SCREEN_COLUMNS + 32'(walk_x));
    assign raddr_fa  = FA_W'(raddr_reg);

    // Column of glyph pixels at the current walk column, one bit per cell row
    for (genvar r = 0; r < SCREEN_ROWS; r++)
    begin : g_col
        if (r < MAX_GLYPH_ROWS)
        begin : g_row
            assign colvec[r] = ~col_cnt_reg[4] & glyph_rows_reg[r][~col_cnt_reg[3:0]];
        end
        else
        begin : g_pad
            assign colvec[r] = 1'b0;
        end
    end

    // Align the column and the cell-height mask to the current page
    always_comb
    begin
        mvec  = ~({SCREEN_ROWS{1'b1}} << font_height_reg);
        sh    = SH_W'(32'(page_cnt_reg) * 8 + 8 - 32'(cy_reg));
        gext  = {colvec, 8'h00} >> sh;
        mext  = {mvec, 8'h00} >> sh;
        set8  = gext[7:0];
        mask8 = mext[7:0];
        val8  = ink_reg ? set8 : ~set8;
    end

    // Frame buffer port selection
    always_comb
    begin
        f_we    = cmd.clear | cmd.col_write;
        f_waddr = cmd.clear ? clr_cnt_reg : walk_addr;
        f_wdata = cmd.clear ? 8'h00 : ((f_rdata_reg & ~mask8) | (val8 & mask8));
        f_re    = cmd.col_read | (cmd.check && (func_reg == FUNC_READ) && raddr_ok);
        f_raddr = cmd.col_read ? walk_addr : raddr_fa;
    end

    // Glyph store
    always_ff @(posedge clk)
    begin
        if (gw_en)
            glyph_mem[gw_addr] <= rbits_reg;
        if (cmd.fetch)
            g_rdata_reg <= glyph_mem[gr_addr];
    end

    // Frame buffer
    always_ff @(posedge clk)
    begin
        if (f_we)
            frame_mem[f_waddr] <= f_wdata;
        if (f_re)
            f_rdata_reg <= frame_mem[f_raddr];
    end

    // Latch the accepted item and the glyph row bank
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg  <= func_t'(func);
            code_reg  <= char_code;
            grow_reg  <= glyph_row;
            rbits_reg <= row_bits;
            ink_reg   <= ink_color;
            setx_reg  <= set_x;
            sety_reg  <= set_y;
            raddr_reg <= read_address;
        end
        if (cap_valid_reg)
            glyph_rows_reg[cap_row_reg] <= g_rdata_reg;
    end

    // Walk counters, output payload
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            status_reg     <= status_c;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            first_page_reg <= PG_W'(cy_reg >> 3);
            page_cnt_reg   <= PG_W'(cy_reg >> 3);
            last_page_reg  <= PG_W'((7'(cy_reg) + 7'(font_height_reg) - 7'd1) >> 3);
            if (font_height_reg > 6'(MAX_GLYPH_ROWS))
                fetch_top_reg <= RW'(MAX_GLYPH_ROWS - 1);
            else
                fetch_top_reg <= RW'(font_height_reg - 6'd1);
        end
        if (cmd.fetch)
        begin
            row_cnt_reg <= row_cnt_reg + RW'(1);
            cap_row_reg <= row_cnt_reg;
        end
        if (cmd.col_write)
        begin
            if (page_cnt_reg == last_page_reg)
            begin
                page_cnt_reg <= first_page_reg;
                col_cnt_reg  <= col_cnt_reg + 5'd1;
            end
            else
            begin
                page_cnt_reg <= page_cnt_reg + PG_W'(1);
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= status_reg;
            out_echo_reg   <= draw_ok ? code_reg : 8'h00;
            out_byte_reg   <= ((func_reg == FUNC_READ) && raddr_ok) ? f_rdata_reg : 8'h00;
        end
    end

    assign draw_ok = (func_reg == FUNC_DRAW) && (status_reg == STATUS_OK);

    // Control state: configuration, cursor, sweep counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_width_reg  <= FONT_W_W'(6);
            font_height_reg <= FONT_H_W'(8);
            cx_reg          <= '0;
            cy_reg          <= '0;
            clr_cnt_reg     <= '0;
            cap_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // write configuration
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FONT_WIDTH:  font_width_reg  <= cfg_data[FONT_W_W-1:0];
                    CFG_FONT_HEIGHT: font_height_reg <= cfg_data[FONT_H_W-1:0];
                    default:         font_width_reg  <= font_width_reg;
                endcase
            end
            // advance the reset sweep
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_reg + FA_W'(1);
            cap_valid_reg <= cmd.fetch;
            // move the cursor when the item completes
            if (cmd.finish)
            begin
                if (func_reg == FUNC_CURSOR)
                begin
                    cx_reg <= setx_reg;
                    cy_reg <= sety_reg;
                end
                else if (draw_ok)
                begin
                    cx_reg <= cx_reg + 8'(font_width_reg);
                end
            end
            // hold the result until taken
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.clear_last = (clr_cnt_reg == FA_W'(FRAME_BYTES - 1));
        stat.draw_go    = (func_reg == FUNC_DRAW) && (status_c == STATUS_OK) &&
                          (font_width_reg != '0) && (font_height_reg != '0);
        stat.fetch_last = (row_cnt_reg == fetch_top_reg);
        stat.walk_last  = (col_cnt_reg == (font_width_reg - 5'd1)) &&
                          (page_cnt_reg == last_page_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign echo_char = out_echo_reg;
    assign read_byte = out_byte_reg;

endmodule

FILE: hdl/glyph_blitter_page_framebuffer.sv
// ----------------------------------------------------------------------------
// glyph_blitter_page_framebuffer
// Character renderer into a page-organized monochrome frame buffer, with a
// loadable glyph store, a text cursor and byte read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame buffer to zero, one byte per cycle,
// over all SCREEN_COLUMNS*SCREEN_ROWS/8 bytes (512 at the default size), and
// takes no item until the sweep ends; configuration writes are taken
// throughout. Items are handled one at a time. Every item passes through
// intake, a check step and a finish step that loads the result register;
// finish waits while an earlier result is still held. Between check and
// finish, a draw character fetches min(font_height, MAX_GLYPH_ROWS) glyph
// rows, one at a time, from the single-port glyph store, then does a
// read-modify-write of each of the font_width * pages frame bytes of the
// cell through the frame buffer's one port, where pages is the number of
// 8-row frame pages the glyph cell touches. A rejected draw, or one with
// zero font width or height, goes from check straight to finish.
// A finished result waits in an output register while the next item is
// accepted.
module glyph_blitter_page_framebuffer #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_ROWS    = 32,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbpf_pkg::CFG_DATA_W-1:0] cfg_data,
    gbpf_in_if.sink                         in_port,
    gbpf_out_if.source                      out_port
);
    import gbpf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    gbpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_port.valid),
        .in_ready (in_port.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Storage and pixel datapath
    gbpf_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .func         (in_port.func),
        .char_code    (in_port.char_code),
        .glyph_row    (in_port.glyph_row),
        .row_bits     (in_port.row_bits),
        .ink_color    (in_port.ink_color),
        .set_x        (in_port.set_x),
        .set_y        (in_port.set_y),
        .read_address (in_port.read_address),
        .out_valid    (out_port.valid),
        .out_ready    (out_port.ready),
        .status       (out_port.status),
        .echo_char    (out_port.echo_char),
        .read_byte    (out_port.read_byte)
    );

endmodule

FILE: hdl/gbpf_checker.sv
// ----------------------------------------------------------------------------
// gbpf_checker
// Port-level checks on the glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
module gbpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [7:0] echo_char,
    input logic [7:0] read_byte
);
    import gbpf_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(echo_char) && $stable(read_byte))
        else $error("result changed while stalled");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_BAD_CODE ||
            status == STATUS_NO_FIT))
        else $error("undefined status code");

    // A rejected item carries no character and no byte
    a_reject_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> echo_char == 8'h00 && read_byte == 8'h00)
        else $error("rejected item carries data");

    // A drawn character and a read byte never come together
    a_draw_or_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && echo_char != 8'h00 |-> read_byte == 8'h00)
        else $error("draw result carries a read byte");

    // One item in flight: intake closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

endmodule

bind glyph_blitter_page_framebuffer gbpf_checker u_gbpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .status    (out_port.status),
    .echo_char (out_port.echo_char),
    .read_byte (out_port.read_byte)
);

FILE: test/glyph_blitter_page_framebuffer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_blitter_page_framebuffer_test
// Self-checking bench for the glyph blitter. A directed table covers reset
// state, code and edge rejection and cells on the screen edges. Random
// sequences then load glyphs, place the cursor, draw text and read the frame
// back under several font sizes. Every result item is checked against a fixed
// table reply or an in-bench model of the frame buffer, glyph store and cursor.
// ----------------------------------------------------------------------------
module glyph_blitter_page_framebuffer_test;
    import gbpf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int COLUMNS       = 128;
    localparam int ROWS          = 32;
    localparam int GLYPH_ROWS    = 32;
    localparam int FRAME_BYTES   = COLUMNS * ROWS / 8;
    localparam int GLYPH_WORDS   = GLYPH_COUNT * GLYPH_ROWS;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 26;
    localparam int NUM_PHASES    = 10;

    typedef struct packed {
        func_t       func;
        logic [7:0]  char_code;
        logic [4:0]  glyph_row;
        logic [15:0] row_bits;
        logic        ink_color;
        logic [7:0]  set_x;
        logic [4:0]  set_y;
        logic [8:0]  read_address;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] echo;
        logic [7:0] rbyte;
    } reply_t;

    typedef struct packed {
        bit       fixed;
        request_t req;
        reply_t   want;
    } directed_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbpf_in_if  req_if ();
    gbpf_out_if rsp_if ();

    // Model state of the block
    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [15:0] glyph_mem [GLYPH_WORDS];
    bit          glyph_known [GLYPH_WORDS];
    logic [7:0]  cursor_x;
    logic [4:0]  cursor_y;
    logic [FONT_W_W-1:0] font_w;
    logic [FONT_H_W-1:0] font_h;

    reply_t     reply_q [$];
    reply_t     expected_reply;
    logic [7:0] pool_codes [4];
    int         items_sent     = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         stall_left;
    bit         gaps_on        = 1'b0;
    bit         stalls_on      = 1'b0;

    int phase_width [NUM_PHASES] = '{6, 1, 16, 31, 31, 20, 0, 5, 8, 16};
    int phase_height [NUM_PHASES] = '{8, 1, 32, 63, 4, 12, 5, 0, 16, 8};
    int phase_items [NUM_PHASES] = '{130, 80, 150, 50, 80, 80, 50, 50, 120, 150};

    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // blank screen after reset, both ends of the buffer
        '{1, '{FUNC_READ, 0, 0, 0, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{1, '{FUNC_READ, 0, 0, 0, 0, 0, 0, 511}, '{STATUS_OK, 0, 0}},
        // loads of codes outside the printable range
        '{1, '{FUNC_LOAD, 31, 0, 'hFFFF, 0, 0, 0, 0}, '{STATUS_BAD_CODE, 0, 0}},
        '{1, '{FUNC_LOAD, 127, 31, 'hFFFF, 1, 0, 0, 0}, '{STATUS_BAD_CODE, 0, 0}},
        '{1, '{FUNC_LOAD, 255, 7, 'h1234, 1, 0, 0, 0}, '{STATUS_BAD_CODE, 0, 0}},
        '{1, '{FUNC_LOAD, 0, 0, 'hFFFF, 0, 0, 0, 0}, '{STATUS_BAD_CODE, 0, 0}},
        // glyph 126: full, empty, edge pixels, stripes
        '{0, '{FUNC_LOAD, 126, 0, 'hFFFF, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 1, 'h0000, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 2, 'h8000, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 3, 'h0001, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 4, 'hAAAA, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 5, 'h5555, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 6, 'hFC00, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_LOAD, 126, 7, 'h0400, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        // last row of the first glyph
        '{0, '{FUNC_LOAD, 32, 31, 'hFFFF, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        // cell touching the right and bottom edges exactly
        '{0, '{FUNC_CURSOR, 0, 0, 0, 0, 122, 24, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_DRAW, 126, 0, 0, 1, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_READ, 0, 0, 0, 0, 0, 0, 506}, '{STATUS_OK, 0, 0}},
        '{1, '{FUNC_DRAW, 126, 0, 0, 1, 0, 0, 0}, '{STATUS_NO_FIT, 0, 0}},
        '{0, '{FUNC_CURSOR, 0, 0, 0, 0, 0, 25, 0}, '{STATUS_OK, 0, 0}},
        '{1, '{FUNC_DRAW, 126, 0, 0, 0, 0, 0, 0}, '{STATUS_NO_FIT, 0, 0}},
        // cell straddling pages 0 and 1, black ink
        '{0, '{FUNC_CURSOR, 0, 0, 0, 0, 3, 5, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_DRAW, 126, 0, 0, 0, 0, 0, 0}, '{STATUS_OK, 0, 0}},
        '{0, '{FUNC_READ, 0, 0, 0, 0, 0, 0, 131}, '{STATUS_OK, 0, 0}},
        // code check wins over the edge check
        '{0, '{FUNC_CURSOR, 0, 0, 0, 0, 255, 31, 0}, '{STATUS_OK, 0, 0}},
        '{1, '{FUNC_DRAW, 127, 0, 0, 0, 0, 0, 0}, '{STATUS_BAD_CODE, 0, 0}}
    };

    glyph_blitter_page_framebuffer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_port   (req_if),
        .out_port  (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the blitter
    // ------------------------------------------------------------------------
    function automatic bit printable(input logic [7:0] code);
        return code >= FIRST_CODE && code <= LAST_CODE;
    endfunction

    function automatic int glyph_base(input logic [7:0] code);
        return (int'(code) - int'(FIRST_CODE)) * GLYPH_ROWS;
    endfunction

    function automatic bit cell_fits();
        return int'(cursor_x) + int'(font_w) <= COLUMNS &&
               int'(cursor_y) + int'(font_h) <= ROWS;
    endfunction

    // True when every glyph row that a draw would fetch has been loaded
    function automatic bit glyph_ready(input logic [7:0] code);
        int rows;
        rows = (int'(font_h) < GLYPH_ROWS) ? int'(font_h) : GLYPH_ROWS;
        for (int row = 0; row < rows; row++)
            if (!glyph_known[glyph_base(code) + row])
                return 1'b0;
        return 1'b1;
    endfunction

    // Write every pixel of the cell at the cursor; clear glyph bits take !ink
    function automatic void paint_glyph(input logic [7:0] code, input logic ink);
        logic [15:0] bits;
        logic        lit;
        int          x;
        int          y;
        for (int row = 0; row < int'(font_h); row++)
        begin
            bits = (row < GLYPH_ROWS) ? glyph_mem[glyph_base(code) + row] : 16'h0000;
            for (int col = 0; col < int'(font_w); col++)
            begin
                lit = (col < 16) ? bits[15 - col] : 1'b0;
                x   = int'(cursor_x) + col;
                y   = int'(cursor_y) + row;
                if (x < COLUMNS && y < ROWS)
                    frame_mem[x + (y / 8) * COLUMNS][y % 8] = lit ? ink : ~ink;
            end
        end
    endfunction

    // Apply one accepted item to the model and return its result item
    function automatic reply_t blit_apply(input request_t r);
        reply_t res;
        int     slot;
        res = '0;
        case (r.func)
            FUNC_LOAD:
            begin
                // glyph_row has 5 bits, so a row beyond the store cannot occur
                if (!printable(r.char_code))
                    res.status = STATUS_BAD_CODE;
                else
                begin
                    slot              = glyph_base(r.char_code) + int'(r.glyph_row);
                    glyph_mem[slot]   = r.row_bits;
                    glyph_known[slot] = 1'b1;
                end
            end
            FUNC_CURSOR:
            begin
                cursor_x = r.set_x;
                cursor_y = r.set_y;
            end
            FUNC_DRAW:
            begin
                if (!printable(r.char_code))
                    res.status = STATUS_BAD_CODE;
                else if (!cell_fits())
                    res.status = STATUS_NO_FIT;
                else
                begin
                    paint_glyph(r.char_code, r.ink_color);
                    cursor_x = cursor_x + 8'(font_w);
                    res.echo = r.char_code;
                end
            end
            default:
            begin
                // the 9-bit address always falls inside the buffer
                res.rbyte = frame_mem[r.read_address];
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic request_t random_request(input func_t f);
        request_t r;
        r.func         = f;
        r.char_code    = 8'($urandom);
        r.glyph_row    = 5'($urandom);
        r.row_bits     = 16'($urandom);
        r.ink_color    = 1'($urandom);
        r.set_x        = 8'($urandom);
        r.set_y        = 5'($urandom);
        r.read_address = 9'($urandom);
        return r;
    endfunction

    function automatic request_t make_load(input logic [7:0] code, input int row);
        request_t r;
        r           = random_request(FUNC_LOAD);
        r.char_code = code;
        r.glyph_row = 5'(row);
        return r;
    endfunction

    function automatic request_t make_draw(input logic [7:0] code);
        request_t r;
        r           = random_request(FUNC_DRAW);
        r.char_code = code;
        return r;
    endfunction

    function automatic request_t make_read(input logic [8:0] addr);
        request_t r;
        r              = random_request(FUNC_READ);
        r.read_address = addr;
        return r;
    endfunction

    // Mostly a position where the cell fits, now and then anywhere
    function automatic request_t place_cursor();
        request_t r;
        r = random_request(FUNC_CURSOR);
        if ($urandom_range(0, 9) != 0)
        begin
            r.set_x = 8'($urandom_range(0, COLUMNS - int'(font_w)));
            if (int'(font_h) <= ROWS)
                r.set_y = 5'($urandom_range(0, ROWS - int'(font_h)));
        end
        return r;
    endfunction

    // Steer a draw that would fetch unloaded rows onto a preloaded glyph
    function automatic logic [7:0] steer_code(input logic [7:0] code);
        if (printable(code) && cell_fits() && !glyph_ready(code))
            return pool_codes[$urandom_range(0, 3)];
        return code;
    endfunction

    function automatic logic [7:0] pick_draw_code();
        logic [7:0] code;
        case ($urandom_range(0, 9))
            0:       code = 8'($urandom);
            1, 2:    code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
            default: code = pool_codes[$urandom_range(0, 3)];
        endcase
        return steer_code(code);
    endfunction

    // Frame byte in or just right of the cells drawn from (x0, y0)
    function automatic logic [8:0] cell_address(input int x0, input int y0, input int span);
        int col;
        int page;
        col  = (x0 + int'($urandom_range(0, span))) % COLUMNS;
        page = (y0 + int'($urandom_range(0, (font_h > 0) ? int'(font_h) - 1 : 0))) / 8;
        if (page > ROWS / 8 - 1)
            page = ROWS / 8 - 1;
        return 9'(col + page * COLUMNS);
    endfunction

    // Drive one item, hold it until accepted, then record its expected result
    task automatic send_request(input request_t r, input bit fixed = 1'b0,
                                input reply_t want = '0);
        reply_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= r.func;
        req_if.char_code    <= r.char_code;
        req_if.glyph_row    <= r.glyph_row;
        req_if.row_bits     <= r.row_bits;
        req_if.ink_color    <= r.ink_color;
        req_if.set_x        <= r.set_x;
        req_if.set_y        <= r.set_y;
        req_if.read_address <= r.read_address;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        predicted = blit_apply(r);
        reply_q.push_back(fixed ? want : predicted);
        items_sent++;
    endtask

    // Write both font registers; this runs only with no item in flight
    task automatic write_font(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FONT_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_FONT_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        font_w = FONT_W_W'(w);
        font_h = FONT_H_W'(h);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    // Load a fresh glyph for the current height, then draw and read it back
    task automatic glyph_program();
        logic [7:0] code;
        int         rows;
        int         x0;
        int         y0;
        code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
        rows = (int'(font_h) < GLYPH_ROWS) ? int'(font_h) : GLYPH_ROWS;
        for (int row = 0; row < rows; row++)
            send_request(make_load(code, row));
        send_request(place_cursor());
        x0 = int'(cursor_x);
        y0 = int'(cursor_y);
        send_request(make_draw(code));
        send_request(make_read(cell_address(x0, y0, int'(font_w))));
    endtask

    // A run of characters from one cursor position, then reads of the cells
    task automatic text_line();
        int x0;
        int y0;
        int count;
        send_request(place_cursor());
        x0    = int'(cursor_x);
        y0    = int'(cursor_y);
        count = $urandom_range(2, 5);
        repeat (count) send_request(make_draw(pick_draw_code()));
        repeat ($urandom_range(1, 4))
            send_request(make_read(cell_address(x0, y0, count * int'(font_w))));
    endtask

    task automatic noise_item();
        request_t r;
        r = random_request(func_t'($urandom_range(0, 3)));
        if (r.func == FUNC_DRAW)
            r.char_code = steer_code(r.char_code);
        send_request(r);
    endtask

    task automatic run_random(input int count, input bit idle);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            gaps_on   = idle && ($urandom_range(0, 3) != 0);
            stalls_on = idle && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2:    glyph_program();
                3, 4, 5, 6: text_line();
                default:    noise_item();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready stalls and the checker
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 14);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (reply_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result item: status %0d echo %0d byte 0x%02h",
                             $time, rsp_if.status, rsp_if.echo_char, rsp_if.read_byte);
            end
            else
            begin
                expected_reply = reply_q.pop_front();
                if (rsp_if.status !== expected_reply.status ||
                    rsp_if.echo_char !== expected_reply.echo ||
                    rsp_if.read_byte !== expected_reply.rbyte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected %0d/%0d/0x%02h, got %0d/%0d/0x%02h",
                                 $time, expected_reply.status, expected_reply.echo,
                                 expected_reply.rbyte, rsp_if.status, rsp_if.echo_char,
                                 rsp_if.read_byte);
                end
            end
        end
    end

    // Hard stop for a hung block
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_FONT_WIDTH;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.func         <= FUNC_LOAD;
        req_if.char_code    <= '0;
        req_if.glyph_row    <= '0;
        req_if.row_bits     <= '0;
        req_if.ink_color    <= 1'b0;
        req_if.set_x        <= '0;
        req_if.set_y        <= '0;
        req_if.read_address <= '0;

        // model state after reset: blank screen, cursor home, default font
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mem[i] = 8'h00;
        for (int i = 0; i < GLYPH_WORDS; i++)
        begin
            glyph_mem[i]   = 16'h0000;
            glyph_known[i] = 1'b0;
        end
        cursor_x = '0;
        cursor_y = '0;
        font_w   = FONT_W_W'(6);
        font_h   = FONT_H_W'(8);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
                drain_results();
            write_font(phase_width[phase], phase_height[phase]);
            if (phase == 0)
            begin
                // directed table under the default font
                for (int i = 0; i < DIRECTED_ROWS; i++)
                    send_request(directed_table[i].req, directed_table[i].fixed,
                                 directed_table[i].want);
                // fully load a small pool of glyphs that draws can fall back on
                pool_codes[0] = FIRST_CODE;
                pool_codes[1] = LAST_CODE;
                pool_codes[2] = 8'($urandom_range(FIRST_CODE + 1, LAST_CODE - 1));
                pool_codes[3] = 8'($urandom_range(FIRST_CODE + 1, LAST_CODE - 1));
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
                for (int g = 0; g < 4; g++)
                    for (int row = 0; row < GLYPH_ROWS; row++)
                        send_request(make_load(pool_codes[g], row));
            end
            // the last phase runs with no idling on either side
            run_random(phase_items[phase], phase < NUM_PHASES - 1);
        end

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: glyph_blitter_page_framebuffer.f
hdl/gbpf_pkg.sv
hdl/gbpf_if.sv
hdl/gbpf_ctrl.sv
hdl/gbpf_datapath.sv
hdl/glyph_blitter_page_framebuffer.sv
hdl/gbpf_checker.sv
test/glyph_blitter_page_framebuffer_test.sv
